[design/izoom_pkg.sv]
// Shared types, register codes and blend arithmetic for the image zoom block.
// Used by the blend unit and the top level; depends on nothing else.
package izoom_pkg;

   // One RGBA pixel as it is held in the frame store.
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_type;

   // Control that the pipeline hands to the blend unit.
   typedef struct packed {
      logic adv;
      logic smooth;
   } blend_ctrl_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] REG_STEP_HORZ  = 3'd2;
   localparam logic [2:0] REG_STEP_VERT  = 3'd3;
   localparam logic [2:0] REG_MIRROR_H   = 3'd4;
   localparam logic [2:0] REG_MIRROR_V   = 3'd5;
   localparam logic [2:0] REG_SMOOTH     = 3'd6;

   // Width of a coordinate times a step product.
   localparam int PROD_W = 36;

   // a + floor((b - a) * f / 65536), kept to 8 bits. Only bits 23:16 of the
   // product survive the final mask, so the shift is a plain part-select.
   function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [15:0] f);
      logic signed [8:0]  d;
      logic signed [25:0] p;
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = d * $signed({1'b0, f});
      return p[23:16] + a;
   endfunction

   function automatic pix_type lerp_pix(input pix_type a, input pix_type b,
                                        input logic [15:0] f);
      pix_type r;
      r.red   = lerp8(a.red,   b.red,   f);
      r.green = lerp8(a.green, b.green, f);
      r.blue  = lerp8(a.blue,  b.blue,  f);
      r.alpha = lerp8(a.alpha, b.alpha, f);
      return r;
   endfunction

endpackage

[design/izoom_ram.sv]
// One bank of the source frame store: one write port, one registered read port.
// Depends on nothing else.
module izoom_ram #(
   parameter int AW = 14
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [31:0]   rdata
);

   logic [31:0] mem [2**AW];
   logic [31:0] rdata_ff;

   // Write and registered read in the same clocked block.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/izoom_blend.sv]
// Two-stage bilinear blend: horizontal pair blends, then the vertical blend; nearest mode passes p00.
// Depends on izoom_pkg for the pixel type and the blend function.
module izoom_blend import izoom_pkg::*; (
   input  logic           clock,
   input  blend_ctrl_type ctrl,
   input  pix_type        p00,
   input  pix_type        p01,
   input  pix_type        p10,
   input  pix_type        p11,
   input  logic [15:0]    frac_x,
   input  logic [15:0]    frac_y,
   output pix_type        pix_out
);

   pix_type     t1_ff, t1_in, t2_ff, t2_in, out_ff, out_in;
   logic [15:0] fy_ff;

   // Horizontal blends; nearest mode passes the base pixel through.
   always_comb begin
      t1_in = ctrl.smooth ? lerp_pix(p00, p01, frac_x) : p00;
      t2_in = lerp_pix(p10, p11, frac_x);
   end

   // Vertical blend into the output register.
   always_comb begin
      out_in = ctrl.smooth ? lerp_pix(t1_ff, t2_ff, fy_ff) : t1_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv) begin
         t1_ff  <= t1_in;
         t2_ff  <= t2_in;
         fy_ff  <= frac_y;
         out_ff <= out_in;
      end
   end

   assign pix_out = out_ff;

endmodule

[design/image_zoom_nearest_bilinear.sv]
// Image zoom, nearest or bilinear, with a four-bank RGBA frame store.
// A produce transaction's result passes the capture, product, position, bank, blend and output stages.
// Throughput: one transaction per cycle; the whole pipeline stalls together.
// Reset: synchronous, active high; clears valid bits and configuration registers, not data registers or the store.
// Depends on izoom_pkg, izoom_ram and izoom_blend.
module image_zoom_nearest_bilinear import izoom_pkg::*; #(
   parameter int MAX_SOURCE_WIDTH  = 256,
   parameter int MAX_SOURCE_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [10:0] req_column,
   input  logic [10:0] req_row,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic [7:0]  req_in_alpha,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_alpha,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW = $clog2(MAX_SOURCE_WIDTH);
   localparam int RH = $clog2(MAX_SOURCE_HEIGHT);
   localparam int WW = $clog2(MAX_SOURCE_WIDTH + 1);
   localparam int HW = $clog2(MAX_SOURCE_HEIGHT + 1);
   localparam int CB = (CW > 1) ? CW - 1 : 1;
   localparam int RB = (RH > 1) ? RH - 1 : 1;
   localparam int AW = CB + RB;

   // Configuration registers.
   logic [8:0]  width_ff, height_ff;
   logic [24:0] steph_ff, stepv_ff;
   logic        mirh_ff, mirv_ff, smooth_ff;
   logic [2:0]  reg_idx;
   logic        csr_wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd240;
         height_ff <= 9'd160;
         steph_ff  <= 25'd65536;
         stepv_ff  <= 25'd65536;
         mirh_ff   <= 1'b0;
         mirv_ff   <= 1'b0;
         smooth_ff <= 1'b0;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_SRC_WIDTH:  width_ff  <= pwdata[8:0];
            REG_SRC_HEIGHT: height_ff <= pwdata[8:0];
            REG_STEP_HORZ:  steph_ff  <= pwdata[24:0];
            REG_STEP_VERT:  stepv_ff  <= pwdata[24:0];
            REG_MIRROR_H:   mirh_ff   <= pwdata[0];
            REG_MIRROR_V:   mirv_ff   <= pwdata[0];
            REG_SMOOTH:     smooth_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (reg_idx)
         REG_SRC_WIDTH:  prdata = {23'd0, width_ff};
         REG_SRC_HEIGHT: prdata = {23'd0, height_ff};
         REG_STEP_HORZ:  prdata = {7'd0, steph_ff};
         REG_STEP_VERT:  prdata = {7'd0, stepv_ff};
         REG_MIRROR_H:   prdata = {31'd0, mirh_ff};
         REG_MIRROR_V:   prdata = {31'd0, mirv_ff};
         REG_SMOOTH:     prdata = {31'd0, smooth_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // Effective image size: zero acts as one, oversize acts as the maximum.
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [CW-1:0] w_m1;
   logic [RH-1:0] h_m1;
   logic [PROD_W-1:0] lim_x, lim_y;

   always_comb begin
      if (width_ff == 9'd0) begin
         w_eff = WW'(1);
      end else if ({2'b0, width_ff} > 11'(MAX_SOURCE_WIDTH)) begin
         w_eff = WW'(MAX_SOURCE_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == 9'd0) begin
         h_eff = HW'(1);
      end else if ({2'b0, height_ff} > 11'(MAX_SOURCE_HEIGHT)) begin
         h_eff = HW'(MAX_SOURCE_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
      w_m1  = CW'(w_eff - WW'(1));
      h_m1  = RH'(h_eff - HW'(1));
      lim_x = {{(PROD_W-WW-16){1'b0}}, w_eff, 16'h0} - PROD_W'(1);
      lim_y = {{(PROD_W-HW-16){1'b0}}, h_eff, 16'h0} - PROD_W'(1);
   end

   // Pipeline advances when the output register is empty or being taken.
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic op1_ff, op2_ff, op3_ff;

   assign adv       = !v6_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff && op3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // Stage 1: transaction capture.  Stage 2: position products.
   // Stage 3: saturated positions; store write and read issue.
   logic [10:0] col1_ff, row1_ff, col2_ff, row2_ff, col3_ff, row3_ff;
   pix_type     pix1_ff, pix2_ff, pix3_ff;
   logic [PROD_W-1:0] prodx_ff, prody_ff, prodx_in, prody_in;
   logic [CW+15:0] posx_ff, posx_in;
   logic [RH+15:0] posy_ff, posy_in;

   always_comb begin
      prodx_in = PROD_W'(col1_ff) * PROD_W'(steph_ff);
      prody_in = PROD_W'(row1_ff) * PROD_W'(stepv_ff);
      posx_in  = (CW+16)'((prodx_ff < lim_x) ? prodx_ff : lim_x);
      posy_in  = (RH+16)'((prody_ff < lim_y) ? prody_ff : lim_y);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff   <= req_op;
         col1_ff  <= req_column;
         row1_ff  <= req_row;
         pix1_ff  <= '{alpha: req_in_alpha, blue: req_in_blue,
                       green: req_in_green, red: req_in_red};
         op2_ff   <= op1_ff;
         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
         pix2_ff  <= pix1_ff;
         prodx_ff <= prodx_in;
         prody_ff <= prody_in;
         op3_ff   <= op2_ff;
         col3_ff  <= col2_ff;
         row3_ff  <= row2_ff;
         pix3_ff  <= pix2_ff;
         posx_ff  <= posx_in;
         posy_ff  <= posy_in;
      end
   end

   // Base and neighbor coordinates, mirrored as configured.
   logic [CW-1:0] cx3, bc3, nc3;
   logic [RH-1:0] cy3, br3, nr3;
   logic          load_ok;

   always_comb begin
      cx3 = posx_ff[CW+15:16];
      cy3 = posy_ff[RH+15:16];
      bc3 = mirh_ff ? (w_m1 - cx3) : cx3;
      br3 = mirv_ff ? (h_m1 - cy3) : cy3;
      nc3 = bc3;
      if (cx3 < w_m1) begin
         nc3 = mirh_ff ? (bc3 - CW'(1)) : (bc3 + CW'(1));
      end
      nr3 = br3;
      if (cy3 < h_m1) begin
         nr3 = mirv_ff ? (br3 - RH'(1)) : (br3 + RH'(1));
      end
      load_ok = (col3_ff < 11'(MAX_SOURCE_WIDTH)) && (row3_ff < 11'(MAX_SOURCE_HEIGHT));
   end

   // Four banks by column and row parity, so the four neighbors never collide.
   logic [31:0] bank_q [4];

   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [CW-1:0] rcol;
      logic [RH-1:0] rrow;
      logic          we;
      assign rcol = (bc3[0] == 1'(k % 2)) ? bc3 : nc3;
      assign rrow = (br3[0] == 1'(k / 2)) ? br3 : nr3;
      assign we   = adv && v3_ff && !op3_ff && load_ok &&
                    (col3_ff[0] == 1'(k % 2)) && (row3_ff[0] == 1'(k / 2));
      izoom_ram #(.AW(AW)) u_ram (
         .clock (clock),
         .we    (we),
         .waddr ({RB'(row3_ff >> 1), CB'(col3_ff >> 1)}),
         .wdata (pix3_ff),
         .re    (adv),
         .raddr ({RB'(rrow >> 1), CB'(rcol >> 1)}),
         .rdata (bank_q[k])
      );
   end

   // Stage 4: bank data arrive; parity bits route them to neighbor roles.
   logic        bc0_ff, nc0_ff, br0_ff, nr0_ff;
   logic [15:0] ex4_ff, ey4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         bc0_ff <= bc3[0];
         nc0_ff <= nc3[0];
         br0_ff <= br3[0];
         nr0_ff <= nr3[0];
         ex4_ff <= posx_ff[15:0];
         ey4_ff <= posy_ff[15:0];
      end
   end

   pix_type        q00, q01, q10, q11, pix_out;
   blend_ctrl_type bctrl;

   assign q00   = bank_q[{br0_ff, bc0_ff}];
   assign q01   = bank_q[{br0_ff, nc0_ff}];
   assign q10   = bank_q[{nr0_ff, bc0_ff}];
   assign q11   = bank_q[{nr0_ff, nc0_ff}];
   assign bctrl = '{adv: adv, smooth: smooth_ff};

   // Stages 5 and 6: blend and output register.
   izoom_blend u_blend (
      .clock   (clock),
      .ctrl    (bctrl),
      .p00     (q00),
      .p01     (q01),
      .p10     (q10),
      .p11     (q11),
      .frac_x  (ex4_ff),
      .frac_y  (ey4_ff),
      .pix_out (pix_out)
   );

   assign rsp_out_red   = pix_out.red;
   assign rsp_out_green = pix_out.green;
   assign rsp_out_blue  = pix_out.blue;
   assign rsp_out_alpha = pix_out.alpha;

   // A reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The saturated position never passes the last source column.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && op3_ff) |-> (cx3 <= w_m1))
      else $error("source column beyond image");

   // The neighbor column lies on the base column or next to it.
   a_neighbor_adjacent: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && op3_ff) |-> (nc3 == bc3 || nc3 == bc3 + CW'(1) || nc3 + CW'(1) == bc3))
      else $error("neighbor column not adjacent");

endmodule
